>>> rtl/core/lpd_pkg.sv
// Shared types and constants for the lidar packet deframer.
// Used by lpd_parser, lidar_packet_deframer and the testbench; no dependencies.
package lpd_pkg;

  // Header bytes and the zero-packet marker bit in the type byte
  localparam logic [7:0] HDR_SYNC0 = 8'hAA;
  localparam logic [7:0] HDR_SYNC1 = 8'h55;
  localparam logic [7:0] TYPE_ZERO_MASK = 8'h01;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_SCAN    = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] distance;
    logic [7:0]  sample_index;
    logic [14:0] start_angle;
    logic [14:0] end_angle;
    logic [7:0]  packet_samples;
    logic        accepted;
    logic [11:0] point_count;
  } res_t;

endpackage

>>> rtl/core/lpd_parser.sv
// Byte-wise packet parser: holds the framing state and forms at most one
// result per byte. Depends on lpd_pkg.
module lpd_parser #(
  parameter int MAX_POINTS = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data,
  output logic          emit,
  output lpd_pkg::res_t res
);

  // Scan count limit, clipped to what 12 bits hold
  localparam int LimInt = (MAX_POINTS > 4095) ? 4095 : MAX_POINTS;
  localparam logic [11:0] LIMIT = 12'(LimInt);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR1, PH_HDR2, PH_TYPE, PH_CNT, PH_SA_LO, PH_SA_HI,
    PH_EA_LO, PH_EA_HI, PH_CK_LO, PH_CK_HI, PH_S_LO, PH_S_HI
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  declared, declared_next;
  logic [7:0]  received, received_next;
  logic [7:0]  low_hold, low_hold_next;
  logic [14:0] start_ang, start_ang_next;
  logic [14:0] end_ang, end_ang_next;
  logic        zero_pkt, zero_pkt_next;
  logic [11:0] points, points_next;
  logic [12:0] sum;

  assign sum = {1'b0, points} + {5'd0, received};

  always_comb begin
    phase_next     = phase;
    declared_next  = declared;
    received_next  = received;
    low_hold_next  = low_hold;
    start_ang_next = start_ang;
    end_ang_next   = end_ang;
    zero_pkt_next  = zero_pkt;
    points_next    = points;
    emit           = 1'b0;
    res            = '0;

    // Phase advance, packet close on the byte after the last sample
    case (phase)
      PH_HDR1:  phase_next = (data == lpd_pkg::HDR_SYNC1) ? PH_HDR2 : PH_IDLE;
      PH_HDR2:  phase_next = PH_TYPE;
      PH_TYPE:  phase_next = PH_CNT;
      PH_CNT:   phase_next = PH_SA_LO;
      PH_SA_LO: phase_next = PH_SA_HI;
      PH_SA_HI: phase_next = PH_EA_LO;
      PH_EA_LO: phase_next = PH_EA_HI;
      PH_EA_HI: phase_next = PH_CK_LO;
      PH_CK_LO: phase_next = PH_CK_HI;
      PH_CK_HI: begin
        phase_next    = PH_S_LO;
        received_next = '0;
      end
      PH_S_LO:  phase_next = PH_S_HI;
      PH_S_HI: begin
        if (received >= declared) begin
          emit               = 1'b1;
          res.start_angle    = start_ang;
          res.end_angle      = end_ang;
          res.packet_samples = received;
          if (data == lpd_pkg::HDR_SYNC0) begin
            phase_next = PH_HDR1;
            res.kind   = lpd_pkg::KIND_COMMIT;
            if (!zero_pkt && (received != 8'd0)) begin
              points_next  = (sum > {1'b0, LIMIT}) ? LIMIT : sum[11:0];
              res.accepted = 1'b1;
            end
          end else begin
            phase_next = PH_IDLE;
            res.kind   = lpd_pkg::KIND_DROP;
          end
        end else begin
          phase_next = PH_S_LO;
        end
      end
      default:  phase_next = (data == lpd_pkg::HDR_SYNC0) ? PH_HDR1 : PH_IDLE;
    endcase

    // Field capture for the phase this byte lands in
    case (phase_next)
      PH_TYPE: begin
        if ((data & lpd_pkg::TYPE_ZERO_MASK) != 8'd0) begin
          zero_pkt_next = 1'b1;
          if (points != 12'd0) begin
            emit            = 1'b1;
            res             = '0;
            res.kind        = lpd_pkg::KIND_SCAN;
            res.point_count = points;
          end
          points_next = '0;
        end else begin
          zero_pkt_next = 1'b0;
        end
      end
      PH_CNT:   declared_next = data;
      PH_SA_LO, PH_EA_LO, PH_S_LO: low_hold_next = data;
      PH_SA_HI: start_ang_next = {data, low_hold[7:1]};
      PH_EA_HI: end_ang_next = {data, low_hold[7:1]};
      PH_S_HI: begin
        emit             = 1'b1;
        res.kind         = lpd_pkg::KIND_SAMPLE;
        res.distance     = {data, low_hold};
        res.sample_index = received_next;
        res.start_angle  = start_ang;
        res.end_angle    = end_ang;
        received_next    = received_next + 8'd1;
      end
      PH_IDLE:  received_next = '0;
      default:  ;
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      declared  <= '0;
      received  <= '0;
      low_hold  <= '0;
      start_ang <= '0;
      end_ang   <= '0;
      zero_pkt  <= 1'b0;
      points    <= '0;
    end else if (step) begin
      phase     <= phase_next;
      declared  <= declared_next;
      received  <= received_next;
      low_hold  <= low_hold_next;
      start_ang <= start_ang_next;
      end_ang   <= end_ang_next;
      zero_pkt  <= zero_pkt_next;
      points    <= points_next;
    end
  end

endmodule

>>> rtl/core/lidar_packet_deframer.sv
// Top level of the lidar packet deframer: input register, parser, result
// register. Depends on lpd_pkg and lpd_parser.
//
// Takes one received byte per transfer and reports samples, packet commit or
// drop, and scan completion. It sustains one byte per clock cycle unless the
// parser stalls; a byte whose result is produced has that result on the
// outputs after the input register and then the result register. The parser
// stalls only when it has a result to hand over and the result register is
// still full and not being taken. Bytes that produce no result never wait on
// the output.
module lidar_packet_deframer #(
  parameter int MAX_POINTS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] distance,
  output logic [7:0]  sample_index,
  output logic [14:0] start_angle,
  output logic [14:0] end_angle,
  output logic [7:0]  packet_samples,
  output logic        accepted,
  output logic [11:0] point_count
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          emit;
  logic          advance;
  logic          out_free;
  lpd_pkg::res_t res;
  lpd_pkg::res_t res_q;

  // Stage advances when its result, if any, has room
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (out_free || !emit);
  assign in_ready = !s1_valid || advance;

  lpd_parser #(
    .MAX_POINTS(MAX_POINTS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .data (s1_byte),
    .emit (emit),
    .res  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign kind           = res_q.kind;
  assign distance       = res_q.distance;
  assign sample_index   = res_q.sample_index;
  assign start_angle    = res_q.start_angle;
  assign end_angle      = res_q.end_angle;
  assign packet_samples = res_q.packet_samples;
  assign accepted       = res_q.accepted;
  assign point_count    = res_q.point_count;

endmodule

>>> tb/sv/lpd_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the lidar packet deframer: follows every byte transfer,
// predicts the result it causes and compares it with the result transfers.
// Depends on lpd_pkg; instantiated beside the block by the testbench top.
module lpd_result_checker #(
  parameter int MAX_POINTS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] distance,
  input  logic [7:0]  sample_index,
  input  logic [14:0] start_angle,
  input  logic [14:0] end_angle,
  input  logic [7:0]  packet_samples,
  input  logic        accepted,
  input  logic [11:0] point_count,
  output int          fail_count,
  output int          results_due
);

  // scan count stops here; 12 bits cannot go past 4095
  localparam int POINT_CAP = (MAX_POINTS > 4095) ? 4095 : MAX_POINTS;

  typedef enum logic [3:0] {
    HUNT, SYNC_SEEN, HDR_DONE, GOT_TYPE, GOT_COUNT, SA_LO, SA_HI,
    EA_LO, EA_HI, CK_LO, CK_HI, DIST_LO, DIST_HI
  } parse_t;

  // predicted parser state
  parse_t      phase;
  logic [7:0]  declared;
  logic [7:0]  received;
  logic [7:0]  low_hold;
  logic [14:0] start_ang;
  logic [14:0] end_ang;
  logic        zero_pkt;
  logic [11:0] scan_points;

  lpd_pkg::res_t pending_results[$];
  lpd_pkg::res_t oldest;

  // Advance the predicted parser by one byte; queue the result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    lpd_pkg::res_t r;
    logic [12:0]   sum;
    bit            produced;
    r = '0;
    produced = 1'b0;
    // next phase, plus the closing-byte decision
    case (phase)
      SYNC_SEEN: phase = (b == lpd_pkg::HDR_SYNC1) ? HDR_DONE : HUNT;
      HDR_DONE:  phase = GOT_TYPE;
      GOT_TYPE:  phase = GOT_COUNT;
      GOT_COUNT: phase = SA_LO;
      SA_LO:     phase = SA_HI;
      SA_HI:     phase = EA_LO;
      EA_LO:     phase = EA_HI;
      EA_HI:     phase = CK_LO;
      CK_LO:     phase = CK_HI;
      CK_HI: begin
        phase = DIST_LO;
        received = '0;
      end
      DIST_LO:   phase = DIST_HI;
      DIST_HI: begin
        if (received >= declared) begin
          r.start_angle = start_ang;
          r.end_angle = end_ang;
          r.packet_samples = received;
          produced = 1'b1;
          if (b == lpd_pkg::HDR_SYNC0) begin
            // commit; this byte also opens the next header
            phase = SYNC_SEEN;
            r.kind = lpd_pkg::KIND_COMMIT;
            if (!zero_pkt && received != 0) begin
              sum = scan_points + received;
              scan_points = (sum > POINT_CAP) ? POINT_CAP[11:0] : sum[11:0];
              r.accepted = 1'b1;
            end
          end else begin
            phase = HUNT;
            r.kind = lpd_pkg::KIND_DROP;
          end
        end else begin
          phase = DIST_LO;
        end
      end
      default:   phase = (b == lpd_pkg::HDR_SYNC0) ? SYNC_SEEN : HUNT;
    endcase

    // what the byte means in the phase just entered
    case (phase)
      GOT_TYPE: begin
        zero_pkt = (b & lpd_pkg::TYPE_ZERO_MASK) != 0;
        if (zero_pkt) begin
          if (scan_points != 0) begin
            r = '0;
            r.kind = lpd_pkg::KIND_SCAN;
            r.point_count = scan_points;
            produced = 1'b1;
          end
          scan_points = '0;
        end
      end
      GOT_COUNT: declared = b;
      SA_LO, EA_LO, DIST_LO: low_hold = b;
      SA_HI: start_ang = {b, low_hold[7:1]};
      EA_HI: end_ang = {b, low_hold[7:1]};
      DIST_HI: begin
        r = '0;
        r.kind = lpd_pkg::KIND_SAMPLE;
        r.distance = {b, low_hold};
        r.sample_index = received;
        r.start_angle = start_ang;
        r.end_angle = end_ang;
        produced = 1'b1;
        received = received + 8'd1;
      end
      HUNT: received = '0;
      default: ;
    endcase

    if (produced) pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare result transfers first, then predict from the byte transfer.
  always @(posedge clk) begin
    if (rst) begin
      phase = HUNT;
      declared = '0;
      received = '0;
      low_hold = '0;
      start_ang = '0;
      end_ang = '0;
      zero_pkt = 1'b0;
      scan_points = '0;
      pending_results.delete();
      fail_count = 0;
      results_due = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result of kind %0d arrived with none expected", kind);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("kind", oldest.kind, kind);
          check_field("distance", oldest.distance, distance);
          check_field("sample_index", oldest.sample_index, sample_index);
          check_field("start_angle", oldest.start_angle, start_angle);
          check_field("end_angle", oldest.end_angle, end_angle);
          check_field("packet_samples", oldest.packet_samples, packet_samples);
          check_field("accepted", oldest.accepted, accepted);
          check_field("point_count", oldest.point_count, point_count);
        end
      end
      if (in_valid && in_ready) deframe_byte(rx_byte);
      results_due = pending_results.size();
    end
  end

endmodule

>>> tb/sv/lidar_packet_deframer_test.sv
`timescale 1ns / 1ps
// Testbench top for lidar_packet_deframer: clock, reset, byte stream, result
// flow control and the verdict. Depends on lpd_pkg, the block and
// lpd_result_checker.
module lidar_packet_deframer_test;

  // scan point cap for the block and the checker
  localparam int SAT_POINTS = 256;
  localparam int RANDOM_BYTES = 290;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [15:0] distance;
  logic [7:0]  sample_index;
  logic [14:0] start_angle;
  logic [14:0] end_angle;
  logic [7:0]  packet_samples;
  logic        accepted;
  logic [11:0] point_count;

  int fail_count;
  int results_due;
  int bytes_sent;
  bit quiet_send;      // no sender gaps for the current packet
  bit header_open;     // last byte was a committing sync byte
  bit long_hold_req;
  bit long_hold_done;

  lidar_packet_deframer #(
    .MAX_POINTS(SAT_POINTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .distance(distance),
    .sample_index(sample_index),
    .start_angle(start_angle),
    .end_angle(end_angle),
    .packet_samples(packet_samples),
    .accepted(accepted),
    .point_count(point_count)
  );

  lpd_result_checker #(
    .MAX_POINTS(SAT_POINTS)
  ) deframe_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .distance(distance),
    .sample_index(sample_index),
    .start_angle(start_angle),
    .end_angle(end_angle),
    .packet_samples(packet_samples),
    .accepted(accepted),
    .point_count(point_count),
    .fail_count(fail_count),
    .results_due(results_due)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transfer; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  // Well-formed packet with random content, optionally with a bad closing byte or cut short.
  task automatic send_frame(input bit zero_type, input int count,
                            input bit close_ok, input int cut_after);
    logic [7:0] frame[$];
    logic [7:0] t;
    int         n;
    t = 8'($urandom_range(0, 255));
    t[0] = zero_type;
    if (!header_open) frame.push_back(lpd_pkg::HDR_SYNC0);
    frame.push_back(lpd_pkg::HDR_SYNC1);
    frame.push_back(t);
    frame.push_back(count[7:0]);
    // angles and check word
    repeat (6) frame.push_back(8'($urandom_range(0, 255)));
    // a declared count of zero still carries one sample
    n = (count == 0) ? 1 : count;
    repeat (2 * n) frame.push_back(8'($urandom_range(0, 255)));
    if (close_ok) begin
      frame.push_back(lpd_pkg::HDR_SYNC0);
    end else begin
      t = 8'($urandom_range(0, 255));
      if (t == lpd_pkg::HDR_SYNC0) t = 8'h00;
      frame.push_back(t);
    end
    header_open = close_ok;
    if (cut_after >= 0 && cut_after < frame.size()) begin
      while (frame.size() > cut_after) void'(frame.pop_back());
      header_open = 1'b0;
    end
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 24);
    return $urandom_range(25, 60);
  endfunction

  // Result side: random stalls, calm stretches, and one long hold-off.
  initial begin : result_side
    int stall;
    int calm;
    stall = 0;
    calm = 0;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (120) @(negedge clk);
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 63) == 0) calm = $urandom_range(30, 100);
        stall = (calm > 0) ? 0 : pick_gap();
      end
    end
  end

  // Byte stimulus and verdict
  initial begin : byte_side
    int random_end;
    int mode;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    quiet_send = 1'b0;
    header_open = 1'b0;
    long_hold_req = 1'b0;
    bytes_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // stray byte, then a sync byte with a wrong second header byte
    send_byte(8'h00);
    send_byte(lpd_pkg::HDR_SYNC0);
    send_byte(8'h54);
    // zero packet with nothing pending: no scan report; declared count
    // zero still carries one sample; commit is not counted
    send_byte(lpd_pkg::HDR_SYNC0);
    send_byte(lpd_pkg::HDR_SYNC1);
    send_byte(8'h01);
    send_byte(8'h00);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h1234);
    send_word(16'hFFFF);
    send_byte(lpd_pkg::HDR_SYNC0);
    // ordinary two-sample packet, opposite angle extremes, counted
    send_byte(lpd_pkg::HDR_SYNC1);
    send_byte(8'hFE);
    send_byte(8'h02);
    send_word(16'h0001);
    send_word(16'hFFFE);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h8001);
    send_byte(lpd_pkg::HDR_SYNC0);
    // zero packet closes the two-point scan; bad closing byte drops it
    send_byte(lpd_pkg::HDR_SYNC1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_word(16'h5555);
    send_word(16'hAAAA);
    send_word(16'h0F0F);
    send_word(16'h7FFF);
    send_byte(8'h55);

    // long packet against a long result hold-off, then one more packet,
    // then a zero packet to report the scan
    long_hold_req = 1'b1;
    send_frame(1'b0, 40, 1'b1, -1);
    send_frame(1'b0, 3, 1'b1, -1);
    send_frame(1'b1, 0, 1'b1, -1);

    // sender pause until every result is out
    in_valid = 1'b0;
    wait (results_due == 0);
    @(negedge clk);

    // random mix: mostly well-formed packets, some cut short, some noise
    random_end = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_end) begin
      quiet_send = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 80) begin
        send_frame($urandom_range(0, 5) == 0, pick_count(),
                   $urandom_range(0, 99) < 88, -1);
      end else if (mode < 92) begin
        send_frame($urandom_range(0, 5) == 0, pick_count(), 1'b1,
                   $urandom_range(1, 14));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        header_open = 1'b0;
      end
    end
    quiet_send = 1'b0;

    // drain, then let the pipeline settle before the verdict
    in_valid = 1'b0;
    wait (results_due == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("lidar_packet_deframer_test OK");
    end else begin
      $display("lidar_packet_deframer_test NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("lidar_packet_deframer_test NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lpd_pkg.sv
rtl/core/lpd_parser.sv
rtl/core/lidar_packet_deframer.sv
tb/sv/lpd_result_checker.sv
tb/sv/lidar_packet_deframer_test.sv
